[hdl/firpcm_pkg.sv]
// Shared types and constants for the 16-bit PCM FIR filter core.
// Used by firpcm_tap_store, firpcm_mac and fir_filter_16bit_pcm_core.
// Depends on nothing.
package firpcm_pkg;

   localparam int SAMPLE_W        = 16;
   localparam int COEF_W          = 16;
   localparam int INDEX_W         = 5;
   localparam int TAPCNT_W        = 6;
   localparam int MAX_TAPS        = 32;
   localparam int COEFF_FRAC_BITS = 14;

   localparam int ADDR_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CNT_W  = $clog2(MAX_TAPS + 1);
   localparam int PROD_W = SAMPLE_W + COEF_W;
   localparam int ACC_W  = PROD_W + CNT_W;

   // Word type on the request channel
   localparam logic ACT_FILTER = 1'b0;
   localparam logic ACT_COEFF  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } seq_state_type;

   typedef struct packed {
      logic                       hist_we;
      logic [ADDR_W-1:0]          hist_waddr;
      logic signed [SAMPLE_W-1:0] hist_wdata;
      logic                       coef_we;
      logic [ADDR_W-1:0]          coef_waddr;
      logic signed [COEF_W-1:0]   coef_wdata;
      logic                       rd_en;
      logic [ADDR_W-1:0]          hist_raddr;
      logic [ADDR_W-1:0]          coef_raddr;
   } store_cmd_type;

endpackage

[hdl/firpcm_tap_store.sv]
// Delay line and coefficient memories with per-entry valid bits.
// Entries never written read as zero. Read data is registered.
// Depends on firpcm_pkg.
module firpcm_tap_store (
   input  logic                                  clock,
   input  logic                                  reset,
   input  firpcm_pkg::store_cmd_type             cmd,
   output logic                                  rd_vld,
   output logic signed [firpcm_pkg::SAMPLE_W-1:0] hist_rd_data,
   output logic signed [firpcm_pkg::COEF_W-1:0]   coef_rd_data
);

   logic signed [firpcm_pkg::SAMPLE_W-1:0] hist_mem [firpcm_pkg::MAX_TAPS];
   logic signed [firpcm_pkg::COEF_W-1:0]   coef_mem [firpcm_pkg::MAX_TAPS];
   logic [firpcm_pkg::MAX_TAPS-1:0]        hist_vld_ff;
   logic [firpcm_pkg::MAX_TAPS-1:0]        coef_vld_ff;
   logic                                   rd_vld_ff;
   logic signed [firpcm_pkg::SAMPLE_W-1:0] hist_rd_ff;
   logic signed [firpcm_pkg::COEF_W-1:0]   coef_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.hist_we) begin
         hist_mem[cmd.hist_waddr] <= cmd.hist_wdata;
      end
      if (cmd.coef_we) begin
         coef_mem[cmd.coef_waddr] <= cmd.coef_wdata;
      end
      if (cmd.rd_en) begin
         hist_rd_ff <= hist_vld_ff[cmd.hist_raddr] ? hist_mem[cmd.hist_raddr] : '0;
         coef_rd_ff <= coef_vld_ff[cmd.coef_raddr] ? coef_mem[cmd.coef_raddr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         coef_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         if (cmd.hist_we) begin
            hist_vld_ff[cmd.hist_waddr] <= 1'b1;
         end
         if (cmd.coef_we) begin
            coef_vld_ff[cmd.coef_waddr] <= 1'b1;
         end
         rd_vld_ff <= cmd.rd_en;
      end
   end

   assign rd_vld       = rd_vld_ff;
   assign hist_rd_data = hist_rd_ff;
   assign coef_rd_data = coef_rd_ff;

endmodule

[hdl/firpcm_mac.sv]
// Shared multiply-accumulate unit: one tap product per cycle, registered,
// then added into the accumulator. Also scales the final sum. Depends on firpcm_pkg.
module firpcm_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   clear,
   input  logic                                   op_vld,
   input  logic signed [firpcm_pkg::SAMPLE_W-1:0] samp,
   input  logic signed [firpcm_pkg::COEF_W-1:0]   coef,
   output logic                                   busy,
   output logic signed [firpcm_pkg::SAMPLE_W-1:0] result
);

   logic signed [firpcm_pkg::PROD_W-1:0] prod_ff;
   logic signed [firpcm_pkg::PROD_W-1:0] prod_in;
   logic                                 prod_vld_ff;
   logic signed [firpcm_pkg::ACC_W-1:0]  acc_ff;
   logic signed [firpcm_pkg::ACC_W-1:0]  acc_in;
   logic signed [firpcm_pkg::ACC_W-1:0]  bias;
   logic signed [firpcm_pkg::ACC_W-1:0]  biased;
   logic signed [firpcm_pkg::ACC_W-1:0]  quot;

   assign prod_in = samp * coef;

   always_comb begin
      acc_in = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + firpcm_pkg::ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         prod_vld_ff <= op_vld;
         acc_ff      <= acc_in;
      end
   end

   // Truncate toward zero: bias negative sums before the arithmetic shift
   always_comb begin
      bias = '0;
      if (acc_ff[firpcm_pkg::ACC_W-1]) begin
         bias = firpcm_pkg::ACC_W'((64'd1 << firpcm_pkg::COEFF_FRAC_BITS) - 64'd1);
      end
      biased = acc_ff + bias;
      quot   = biased >>> firpcm_pkg::COEFF_FRAC_BITS;
   end

   assign busy   = prod_vld_ff;
   assign result = $signed(quot[firpcm_pkg::SAMPLE_W-1:0]);

endmodule

[hdl/fir_filter_16bit_pcm_core.sv]
// Top level of the 16-bit PCM direct-form FIR filter core.
// Instantiates firpcm_tap_store and firpcm_mac; depends on firpcm_pkg.
//
// Each request word either filters one signed 16-bit sample (action 0) or
// loads one signed Q2.14 coefficient (action 1). A sample is pushed into a
// zero-initialized delay line and the core returns the sum over the active
// taps of coefficient times delayed sample, scaled down by 2^14 with
// truncation toward zero and wrapped to 16 bits. The number of taps in use
// comes from csr_tap_count (reset 1, values above 32 act as 32, zero gives a
// zero output). A coefficient word returns no word. After a sample word is
// taken, req_ready stays low through the tap reads, one per active tap,
// a step that closes the run, the drain of the registered read and of the
// product register, and the hand-over of the sum to the output register.
// A new sample word is thus taken only after the last sum is handed over.
// A single shared multiplier handles one tap per cycle behind a registered
// memory read. A finished result waits in the output register, so the next
// request word can be taken while it waits; the hand-over itself holds
// while an older result still sits unread in that register.
// csr_tap_count is meant to be written only while the core is idle.
module fir_filter_16bit_pcm_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_action,
   input  logic signed [firpcm_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic [firpcm_pkg::INDEX_W-1:0]         req_coeff_index,
   input  logic signed [firpcm_pkg::COEF_W-1:0]   req_coeff_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [firpcm_pkg::SAMPLE_W-1:0] rsp_sample_out,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [firpcm_pkg::TAPCNT_W-1:0]        csr_tap_count
);

   firpcm_pkg::seq_state_type              state_ff, state_in;
   logic [firpcm_pkg::ADDR_W-1:0]          newest_ff, newest_in;
   logic [firpcm_pkg::TAPCNT_W-1:0]        tap_cnt_ff;
   logic [firpcm_pkg::CNT_W-1:0]           tap_idx_ff, tap_idx_in;
   logic [firpcm_pkg::CNT_W-1:0]           taps_eff;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic signed [firpcm_pkg::SAMPLE_W-1:0] rsp_data_ff;
   logic                                   rsp_load;
   logic                                   req_accept;
   logic                                   samp_accept;
   logic                                   coef_accept;
   logic [firpcm_pkg::ADDR_W-1:0]          newest_next;
   logic [firpcm_pkg::ADDR_W-1:0]          tap_lo;
   logic [firpcm_pkg::ADDR_W-1:0]          hist_raddr;
   firpcm_pkg::store_cmd_type              store_cmd;
   logic                                   rd_vld;
   logic signed [firpcm_pkg::SAMPLE_W-1:0] hist_rd_data;
   logic signed [firpcm_pkg::COEF_W-1:0]   coef_rd_data;
   logic                                   mac_busy;
   logic signed [firpcm_pkg::SAMPLE_W-1:0] mac_result;

   // Take request words only between samples
   assign req_ready   = (state_ff == firpcm_pkg::ST_IDLE);
   assign req_accept  = req_valid && req_ready;
   assign samp_accept = req_accept && (req_action == firpcm_pkg::ACT_FILTER);
   assign coef_accept = req_accept && (req_action == firpcm_pkg::ACT_COEFF);
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_cnt_ff <= firpcm_pkg::TAPCNT_W'(1);
      end else if (csr_valid && csr_ready) begin
         tap_cnt_ff <= csr_tap_count;
      end
   end

   // Clamp the tap count to the depth of the delay line
   always_comb begin
      if (int'(tap_cnt_ff) > firpcm_pkg::MAX_TAPS) begin
         taps_eff = firpcm_pkg::CNT_W'(firpcm_pkg::MAX_TAPS);
      end else begin
         taps_eff = firpcm_pkg::CNT_W'(tap_cnt_ff);
      end
   end

   // Advance the newest slot, wrapping at the end of the delay line
   always_comb begin
      if (int'(newest_ff) == firpcm_pkg::MAX_TAPS - 1) begin
         newest_next = '0;
      end else begin
         newest_next = newest_ff + firpcm_pkg::ADDR_W'(1);
      end
   end

   // Slot of the sample tap_idx steps back from the newest
   assign tap_lo = tap_idx_ff[firpcm_pkg::ADDR_W-1:0];
   always_comb begin
      if (newest_ff >= tap_lo) begin
         hist_raddr = newest_ff - tap_lo;
      end else begin
         hist_raddr = firpcm_pkg::ADDR_W'(({1'b0, newest_ff}
                      + (firpcm_pkg::ADDR_W + 1)'(firpcm_pkg::MAX_TAPS))
                      - {1'b0, tap_lo});
      end
   end

   // Sequencer: issue one tap read per cycle, drain the MAC pipe, then
   // hand the scaled sum to the output register once it is free.
   always_comb begin
      state_in   = state_ff;
      newest_in  = newest_ff;
      tap_idx_in = tap_idx_ff;
      rsp_load   = 1'b0;
      store_cmd  = '0;

      store_cmd.hist_waddr = newest_next;
      store_cmd.hist_wdata = req_sample_in;
      store_cmd.coef_waddr = firpcm_pkg::ADDR_W'(req_coeff_index);
      store_cmd.coef_wdata = req_coeff_value;
      store_cmd.hist_raddr = hist_raddr;
      store_cmd.coef_raddr = tap_lo;

      case (state_ff)
         firpcm_pkg::ST_IDLE: begin
            if (samp_accept) begin
               store_cmd.hist_we = 1'b1;
               newest_in         = newest_next;
               tap_idx_in        = '0;
               state_in          = firpcm_pkg::ST_RUN;
            end
            if (coef_accept && (int'(req_coeff_index) < firpcm_pkg::MAX_TAPS)) begin
               store_cmd.coef_we = 1'b1;
            end
         end
         firpcm_pkg::ST_RUN: begin
            if (tap_idx_ff == taps_eff) begin
               state_in = firpcm_pkg::ST_DRAIN;
            end else begin
               store_cmd.rd_en = 1'b1;
               tap_idx_in      = tap_idx_ff + firpcm_pkg::CNT_W'(1);
            end
         end
         firpcm_pkg::ST_DRAIN: begin
            if (!rd_vld && !mac_busy) begin
               state_in = firpcm_pkg::ST_DONE;
            end
         end
         firpcm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = firpcm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = firpcm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= firpcm_pkg::ST_IDLE;
         newest_ff    <= '0;
         tap_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         newest_ff    <= newest_in;
         tap_idx_ff   <= tap_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result word until it is taken
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= mac_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   firpcm_tap_store u_store (
      .clock        (clock),
      .reset        (reset),
      .cmd          (store_cmd),
      .rd_vld       (rd_vld),
      .hist_rd_data (hist_rd_data),
      .coef_rd_data (coef_rd_data)
   );

   firpcm_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .clear  (samp_accept),
      .op_vld (rd_vld),
      .samp   (hist_rd_data),
      .coef   (coef_rd_data),
      .busy   (mac_busy),
      .result (mac_result)
   );

   // Tap counter never runs past the active tap count
   a_tap_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == firpcm_pkg::ST_RUN) |-> (tap_idx_ff <= taps_eff))
      else $error("tap counter ran past the active tap count");

   // A result word appears only when a finished sum is handed over
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == firpcm_pkg::ST_DONE))
      else $error("result word raised outside the hand-over step");

   // A coefficient word starts no computation
   a_coef_no_run: assert property (@(posedge clock) disable iff (reset)
      coef_accept |=> (state_ff == firpcm_pkg::ST_IDLE))
      else $error("coefficient word started a computation");

   // The MAC pipe is empty whenever new words can be taken
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == firpcm_pkg::ST_IDLE) |-> (!rd_vld && !mac_busy))
      else $error("MAC pipe still busy while idle");

endmodule

[tb/fir_filter_16bit_pcm_core_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for fir_filter_16bit_pcm_core: directed and random words,
// with a cycle-accurate-free software predictor kept in a small scoreboard class.
// Depends on firpcm_pkg and fir_filter_16bit_pcm_core.
module fir_filter_16bit_pcm_core_test;

   // Track the filter state and hold the filtered samples still owed by the core.
   class pcm_fir_tracker_type;
      logic signed [firpcm_pkg::SAMPLE_W-1:0] delay_line [firpcm_pkg::MAX_TAPS];
      logic signed [firpcm_pkg::COEF_W-1:0]   coef_bank [firpcm_pkg::MAX_TAPS];
      int                                     head;
      int                                     tap_count;
      logic signed [firpcm_pkg::SAMPLE_W-1:0] owed_samples [$];
      int                                     mismatches;

      function new();
         for (int i = 0; i < firpcm_pkg::MAX_TAPS; i++) begin
            delay_line[i] = '0;
            coef_bank[i]  = '0;
         end
         head       = 0;
         tap_count  = 1;
         mismatches = 0;
      endfunction

      // Shift one sample in and return the truncated, wrapped dot product.
      function logic signed [firpcm_pkg::SAMPLE_W-1:0] filter_sample(
         logic signed [firpcm_pkg::SAMPLE_W-1:0] pcm);
         longint acc;
         longint quo;
         int     active;
         int     j;
         head = (head + 1) % firpcm_pkg::MAX_TAPS;
         delay_line[head] = pcm;
         active = (tap_count > firpcm_pkg::MAX_TAPS) ? firpcm_pkg::MAX_TAPS : tap_count;
         acc = 0;
         for (j = 0; j < active; j++)
            acc += longint'(coef_bank[j]) * longint'(
                   delay_line[(head + firpcm_pkg::MAX_TAPS - j) % firpcm_pkg::MAX_TAPS]);
         // Round toward zero, not toward minus infinity
         if (acc < 0)
            quo = -((-acc) >>> firpcm_pkg::COEFF_FRAC_BITS);
         else
            quo = acc >>> firpcm_pkg::COEFF_FRAC_BITS;
         return quo[firpcm_pkg::SAMPLE_W-1:0];
      endfunction

      function void take_word(logic act, logic signed [firpcm_pkg::SAMPLE_W-1:0] pcm,
                              logic [firpcm_pkg::INDEX_W-1:0] idx,
                              logic signed [firpcm_pkg::COEF_W-1:0] coef);
         if (act == firpcm_pkg::ACT_COEFF)
            coef_bank[idx] = coef;
         else
            owed_samples.push_back(filter_sample(pcm));
      endfunction

      task report_miss(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_sample(logic signed [firpcm_pkg::SAMPLE_W-1:0] got);
         logic signed [firpcm_pkg::SAMPLE_W-1:0] want;
         if (owed_samples.size() == 0) begin
            report_miss($sformatf("rsp word 0x%h with no sample owed", got));
         end else begin
            want = owed_samples.pop_front();
            if (got !== want)
               report_miss($sformatf("rsp_sample_out 0x%h, expected 0x%h", got, want));
         end
      endtask
   endclass

   localparam int STALL_LIMIT     = 3000;  // cycles without any handshake
   localparam int SETTLE_CYCLES   = 40;    // idle wait before a tap count write
   localparam int NUM_PHASES      = 12;
   localparam int ITEMS_PER_PHASE = 138;
   localparam int CALM_PHASE      = 3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                   req_valid       = 1'b0;
   logic                                   req_ready;
   logic                                   req_action      = firpcm_pkg::ACT_FILTER;
   logic signed [firpcm_pkg::SAMPLE_W-1:0] req_sample_in   = '0;
   logic [firpcm_pkg::INDEX_W-1:0]         req_coeff_index = '0;
   logic signed [firpcm_pkg::COEF_W-1:0]   req_coeff_value = '0;
   logic                                   rsp_valid;
   logic                                   rsp_ready       = 1'b0;
   logic signed [firpcm_pkg::SAMPLE_W-1:0] rsp_sample_out;
   logic                                   csr_valid       = 1'b0;
   logic                                   csr_ready;
   logic [firpcm_pkg::TAPCNT_W-1:0]        csr_tap_count   = firpcm_pkg::TAPCNT_W'(1);

   pcm_fir_tracker_type tracker;
   bit                  calm = 1'b0;
   int                  stall_cycles = 0;
   int                  phase_taps [NUM_PHASES] = '{32, 7, 0, 63, 2, 31, 33, 16, 1, 24, 5, 32};

   fir_filter_16bit_pcm_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_sample_in   (req_sample_in),
      .req_coeff_index (req_coeff_index),
      .req_coeff_value (req_coeff_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_out  (rsp_sample_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_tap_count   (csr_tap_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Sample outputs in the active region of the edge, before any NBA lands, so
   // the values seen are the ones the edge itself acts on.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_sample(rsp_sample_out);
      // Stall the receiver about 18 percent of the time, except in the calm stretch
      rsp_ready <= calm || ($urandom_range(99) >= 18);
   end

   // Watchdog: end the run if nothing moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("fir_filter_16bit_pcm_core regression: fail");
         $finish;
      end
   end

   // Bias values toward the corners of the 16-bit range.
   function automatic logic [15:0] pick_value();
      case ($urandom_range(9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Present one request word and hold it until accepted. Valid is only
   // lowered for a random gap; back-to-back words keep it high.
   task automatic send_word(input logic act, input logic [15:0] pcm,
                            input logic [firpcm_pkg::INDEX_W-1:0] idx,
                            input logic [15:0] coef);
      if (!calm && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_sample_in   <= pcm;
      req_coeff_index <= idx;
      req_coeff_value <= coef;
      do @(posedge clock); while (!(req_valid && req_ready));
      tracker.take_word(act, pcm, idx, coef);
   endtask

   // Drain the core, let any trailing coefficient word settle, then write
   // the tap count while nothing is in flight.
   task automatic load_tap_count(input int count);
      req_valid <= 1'b0;
      while (tracker.owed_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid     <= 1'b1;
      csr_tap_count <= count[firpcm_pkg::TAPCNT_W-1:0];
      do @(posedge clock); while (!(csr_valid && csr_ready));
      tracker.tap_count = count[firpcm_pkg::TAPCNT_W-1:0];
      csr_valid <= 1'b0;
   endtask

   initial begin
      int p;
      int k;
      int active;
      tracker = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset tap count of one: all coefficients zero first
      send_word(firpcm_pkg::ACT_FILTER, 16'h7FFF, 5'd0, 16'h0000);
      send_word(firpcm_pkg::ACT_COEFF, 16'h0000, 5'd0, 16'h4000);    // unity gain on tap 0
      send_word(firpcm_pkg::ACT_FILTER, 16'h7FFF, 5'd31, 16'hFFFF);
      send_word(firpcm_pkg::ACT_FILTER, 16'h8000, 5'd0, 16'h0000);
      send_word(firpcm_pkg::ACT_FILTER, 16'hFFFF, 5'd0, 16'h0000);
      send_word(firpcm_pkg::ACT_FILTER, 16'h0001, 5'd0, 16'h0000);
      send_word(firpcm_pkg::ACT_COEFF, 16'hFFFF, 5'd0, 16'h8000);    // gain of -2.0
      send_word(firpcm_pkg::ACT_FILTER, 16'h8000, 5'd0, 16'h0000);   // +65536 wraps to zero
      send_word(firpcm_pkg::ACT_FILTER, 16'h7FFF, 5'd0, 16'h0000);
      send_word(firpcm_pkg::ACT_COEFF, 16'h0000, 5'd0, 16'hFFFF);    // smallest negative gain
      send_word(firpcm_pkg::ACT_FILTER, 16'h0001, 5'd0, 16'h0000);   // -1/16384 truncates to zero
      send_word(firpcm_pkg::ACT_FILTER, 16'hFFFF, 5'd0, 16'h0000);
      send_word(firpcm_pkg::ACT_COEFF, 16'h0000, 5'd31, 16'h7FFF);
      send_word(firpcm_pkg::ACT_COEFF, 16'h0000, 5'd1, 16'h8000);
      // Zero taps still shift the sample in and give zero
      load_tap_count(0);
      send_word(firpcm_pkg::ACT_FILTER, 16'h3039, 5'd0, 16'h0000);
      send_word(firpcm_pkg::ACT_FILTER, 16'h8000, 5'd0, 16'h0000);
      // Tap count above the array size acts as the full 32 taps
      load_tap_count(63);
      send_word(firpcm_pkg::ACT_FILTER, 16'h8000, 5'd0, 16'h0000);
      send_word(firpcm_pkg::ACT_FILTER, 16'h7FFF, 5'd0, 16'h0000);
      send_word(firpcm_pkg::ACT_FILTER, 16'h8000, 5'd0, 16'h0000);

      // Random phases: load the active coefficients first, then mostly samples
      // with a sprinkle of coefficient rewrites
      for (p = 0; p < NUM_PHASES; p++) begin
         load_tap_count(phase_taps[p]);
         calm   = (p == CALM_PHASE);
         active = (phase_taps[p] > firpcm_pkg::MAX_TAPS) ? firpcm_pkg::MAX_TAPS : phase_taps[p];
         for (k = 0; k < active; k++)
            send_word(firpcm_pkg::ACT_COEFF, pick_value(), k[firpcm_pkg::INDEX_W-1:0],
                      pick_value());
         for (k = active; k < ITEMS_PER_PHASE; k++)
            send_word(($urandom_range(99) < 15) ? firpcm_pkg::ACT_COEFF : firpcm_pkg::ACT_FILTER,
                      pick_value(),
                      firpcm_pkg::INDEX_W'($urandom_range(firpcm_pkg::MAX_TAPS - 1)),
                      pick_value());
      end
      calm = 1'b0;

      // Drop valid, wait out the owed samples, then give stray words a chance
      req_valid <= 1'b0;
      while (tracker.owed_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES + 20) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.owed_samples.size() == 0)
         $display("fir_filter_16bit_pcm_core regression: pass");
      else
         $display("fir_filter_16bit_pcm_core regression: fail");
      $finish;
   end

endmodule

[files.f]
hdl/firpcm_pkg.sv
hdl/firpcm_tap_store.sv
hdl/firpcm_mac.sv
hdl/fir_filter_16bit_pcm_core.sv
tb/fir_filter_16bit_pcm_core_test.sv
